### rtl/core/swbc_pkg.sv
// ----------------------------------------------------------------------------
// swbc_pkg
// Shared types, constants and helpers for the stop-and-wait byte channel.
// ----------------------------------------------------------------------------
package swbc_pkg;

   // Ring geometry
   localparam int unsigned RING_DEPTH = 32;
   localparam int unsigned PTR_W      = $clog2(RING_DEPTH);

   // Front queue depth is fixed at two words, one-bit pointers
   localparam int unsigned QUEUE_DEPTH = 2;

   // Request action codes
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_STEP  = 2'd2;

   // Mailbox control flag bit positions
   localparam int unsigned FLAG_ACK_BIT = 0;
   localparam int unsigned FLAG_DAT_BIT = 1;

   // Reset values
   localparam logic [31:0] LAST_ACC_RESET = 32'hFFFF_FFFF;
   localparam logic [2:0]  ZONE_RESET     = 3'd1;

   // Classified operation
   typedef enum logic [3:0] {
      OP_NOP   = 4'b0001,
      OP_WRITE = 4'b0010,
      OP_READ  = 4'b0100,
      OP_STEP  = 4'b1000
   } op_type;

   // One classified word handed from front to back
   typedef struct packed {
      op_type      op;
      logic [7:0]  wr_data;
      logic        dat_flag;
      logic        ack_flag;
      logic [31:0] rx_index;
      logic [31:0] rx_ack;
      logic [7:0]  rx_data;
   } item_type;

   // Ring pointer advance with wrap
   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      n = p + 1'b1;
      if (p == PTR_W'(RING_DEPTH - 1)) begin
         n = '0;
      end
      return n;
   endfunction

endpackage

### rtl/core/swbc_front.sv
// ----------------------------------------------------------------------------
// swbc_front
// Accepts request words, classifies the action and queues them for the back.
// ----------------------------------------------------------------------------
module swbc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic [7:0]          req_wr_data,
   input  logic [1:0]          req_rx_ctl,
   input  logic [31:0]         req_rx_index,
   input  logic [31:0]         req_rx_ack,
   input  logic [7:0]          req_rx_data,
   output logic                q_valid,
   input  logic                q_pop,
   output swbc_pkg::item_type  q_item
);

   swbc_pkg::item_type q_mem_ff [swbc_pkg::QUEUE_DEPTH];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push;
   swbc_pkg::item_type cls;

   // Classify the incoming word
   always_comb begin
      cls.wr_data  = req_wr_data;
      cls.dat_flag = req_rx_ctl[swbc_pkg::FLAG_DAT_BIT];
      cls.ack_flag = req_rx_ctl[swbc_pkg::FLAG_ACK_BIT];
      cls.rx_index = req_rx_index;
      cls.rx_ack   = req_rx_ack;
      cls.rx_data  = req_rx_data;
      case (req_action)
         swbc_pkg::ACT_WRITE: cls.op = swbc_pkg::OP_WRITE;
         swbc_pkg::ACT_READ:  cls.op = swbc_pkg::OP_READ;
         swbc_pkg::ACT_STEP:  cls.op = swbc_pkg::OP_STEP;
         default:             cls.op = swbc_pkg::OP_NOP;
      endcase
   end

   // Queue control
   assign req_stall = (count_ff == 2'(swbc_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

### rtl/core/swbc_back.sv
// ----------------------------------------------------------------------------
// swbc_back
// Executes queued words against the rings and the protocol state, and holds
// the result word in an output register.
// ----------------------------------------------------------------------------
module swbc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_partner_zone,
   input  logic                q_valid,
   output logic                q_pop,
   input  swbc_pkg::item_type  q_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_local_ok,
   output logic [7:0]          rsp_rd_data,
   output logic                rsp_send_now,
   output logic [2:0]          rsp_dest_zone,
   output logic [1:0]          rsp_tx_ctl,
   output logic [31:0]         rsp_tx_ack,
   output logic [31:0]         rsp_tx_index,
   output logic [7:0]          rsp_tx_data
);

   localparam int unsigned PW = swbc_pkg::PTR_W;

   // Ring storage, undefined until written
   logic [7:0] tx_mem [swbc_pkg::RING_DEPTH];
   logic [7:0] rx_mem [swbc_pkg::RING_DEPTH];

   // Protocol state
   logic [2:0]    zone_ff;
   logic [PW-1:0] tx_head_ff, tx_head_in;
   logic [PW-1:0] tx_tail_ff, tx_tail_in;
   logic [PW-1:0] rx_head_ff, rx_head_in;
   logic [PW-1:0] rx_tail_ff, rx_tail_in;
   logic          await_ff, await_in;
   logic [31:0]   seq_ff, seq_in;
   logic [31:0]   last_acc_ff, last_acc_in;
   logic [1:0]    sticky_ff, sticky_in;
   logic [31:0]   held_idx_ff, held_idx_in;

   // Memory read registers; tx_rdata_ff is the held outgoing byte
   logic [7:0]    tx_rdata_ff;
   logic [7:0]    rx_rdata_ff;

   // Result register
   logic          s2_valid_ff, s2_valid_in;
   logic          s2_ok_ff, s2_ok_in;
   logic          s2_send_ff, s2_send_in;
   logic [2:0]    s2_zone_ff, s2_zone_in;
   logic [1:0]    s2_ctl_ff, s2_ctl_in;
   logic [31:0]   s2_ack_ff, s2_ack_in;
   logic [31:0]   s2_idx_ff, s2_idx_in;
   // Held result came from a read
   logic          s2_rd_ff;

   logic          exec;
   logic          tx_we, rx_we, tx_re, rx_re;
   logic          ok;
   logic          acc, ack_hit, adv, load, flush;
   logic [PW-1:0] head_adv;

   assign csr_ready = 1'b1;

   // Execute when the result register is free or being drained
   assign exec  = q_valid && (!s2_valid_ff || !rsp_stall);
   assign q_pop = exec;

   // Step decisions
   always_comb begin
      acc      = q_item.dat_flag && (q_item.rx_index == last_acc_ff + 32'd1);
      ack_hit  = q_item.ack_flag && await_ff;
      adv      = ack_hit && (q_item.rx_ack == seq_ff);
      head_adv = adv ? swbc_pkg::ring_next(tx_head_ff) : tx_head_ff;
      load     = !(await_ff && !ack_hit) && (head_adv != tx_tail_ff);
      flush    = acc || load;
   end

   // Next state and result word
   always_comb begin
      tx_head_in  = tx_head_ff;
      tx_tail_in  = tx_tail_ff;
      rx_head_in  = rx_head_ff;
      rx_tail_in  = rx_tail_ff;
      await_in    = await_ff;
      seq_in      = seq_ff;
      last_acc_in = last_acc_ff;
      sticky_in   = sticky_ff;
      held_idx_in = held_idx_ff;
      ok          = 1'b0;
      tx_we       = 1'b0;
      rx_we       = 1'b0;
      tx_re       = 1'b0;
      rx_re       = 1'b0;
      s2_ok_in    = 1'b0;
      s2_send_in  = 1'b0;
      s2_zone_in  = 3'd0;
      s2_ctl_in   = 2'd0;
      s2_ack_in   = 32'd0;
      s2_idx_in   = 32'd0;
      case (q_item.op)
         swbc_pkg::OP_WRITE: begin
            ok = (tx_head_ff != swbc_pkg::ring_next(tx_tail_ff));
            if (ok) begin
               tx_tail_in = swbc_pkg::ring_next(tx_tail_ff);
               tx_we      = exec;
            end
            s2_ok_in = ok;
         end
         swbc_pkg::OP_READ: begin
            ok = (rx_head_ff != rx_tail_ff);
            if (ok) begin
               rx_head_in = swbc_pkg::ring_next(rx_head_ff);
               rx_re      = exec;
            end
            s2_ok_in = ok;
         end
         swbc_pkg::OP_STEP: begin
            if (acc) begin
               rx_tail_in = swbc_pkg::ring_next(rx_tail_ff);
               rx_we      = exec;
               sticky_in[swbc_pkg::FLAG_ACK_BIT] = 1'b1;
               last_acc_in = q_item.rx_index;
            end
            tx_head_in = head_adv;
            if (adv) begin
               seq_in = seq_ff + 32'd1;
            end
            if (ack_hit) begin
               await_in = 1'b0;
            end
            if (load) begin
               sticky_in[swbc_pkg::FLAG_DAT_BIT] = 1'b1;
               held_idx_in = adv ? seq_ff + 32'd1 : seq_ff;
               await_in    = 1'b1;
               tx_re       = exec;
            end
            if (flush) begin
               s2_send_in = 1'b1;
               s2_zone_in = zone_ff;
               s2_ctl_in  = sticky_in;
               s2_ack_in  = last_acc_in;
               s2_idx_in  = held_idx_in;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (exec) begin
         s2_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff     <= swbc_pkg::ZONE_RESET;
         tx_head_ff  <= '0;
         tx_tail_ff  <= '0;
         rx_head_ff  <= '0;
         rx_tail_ff  <= '0;
         await_ff    <= 1'b0;
         seq_ff      <= 32'd0;
         last_acc_ff <= swbc_pkg::LAST_ACC_RESET;
         sticky_ff   <= 2'd0;
         held_idx_ff <= 32'd0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            zone_ff <= csr_partner_zone;
         end
         if (exec) begin
            tx_head_ff  <= tx_head_in;
            tx_tail_ff  <= tx_tail_in;
            rx_head_ff  <= rx_head_in;
            rx_tail_ff  <= rx_tail_in;
            await_ff    <= await_in;
            seq_ff      <= seq_in;
            last_acc_ff <= last_acc_in;
            sticky_ff   <= sticky_in;
            held_idx_ff <= held_idx_in;
         end
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (exec) begin
         s2_ok_ff   <= s2_ok_in;
         s2_send_ff <= s2_send_in;
         s2_zone_ff <= s2_zone_in;
         s2_ctl_ff  <= s2_ctl_in;
         s2_ack_ff  <= s2_ack_in;
         s2_idx_ff  <= s2_idx_in;
         s2_rd_ff   <= (q_item.op == swbc_pkg::OP_READ);
      end
   end

   // Transmit ring
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_tail_ff] <= q_item.wr_data;
      end
   end

   // Held byte starts at zero, reloaded on each send load
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_rdata_ff <= 8'd0;
      end else if (tx_re) begin
         tx_rdata_ff <= tx_mem[head_adv];
      end
   end

   // Receive ring
   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_tail_ff] <= q_item.rx_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rx_re) begin
         rx_rdata_ff <= rx_mem[rx_head_ff];
      end
   end

   // Outputs; local_ok is only set by a successful read or write
   assign rsp_valid     = s2_valid_ff;
   assign rsp_local_ok  = s2_ok_ff;
   assign rsp_rd_data   = (s2_ok_ff && !s2_send_ff && s2_rd_ff) ? rx_rdata_ff : 8'd0;
   assign rsp_send_now  = s2_send_ff;
   assign rsp_dest_zone = s2_zone_ff;
   assign rsp_tx_ctl    = s2_ctl_ff;
   assign rsp_tx_ack    = s2_ack_ff;
   assign rsp_tx_index  = s2_idx_ff;
   assign rsp_tx_data   = s2_send_ff ? tx_rdata_ff : 8'd0;

endmodule

### rtl/core/stop_and_wait_byte_channel_core.sv
// ----------------------------------------------------------------------------
// stop_and_wait_byte_channel_core
// Byte channel to a mailbox partner with stop-and-wait sequencing.
// ----------------------------------------------------------------------------
// Path: a request is accepted into the front queue, then the execute stage
//   writes its result into the result register.
// Throughput: one word per cycle while the result side does not stall.
// Reset: ring pointers, sequence state and flags clear, last accepted index
//   goes to all ones, partner zone to 1. Ring storage is not cleared.
module stop_and_wait_byte_channel_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_partner_zone,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_wr_data,
   input  logic [1:0]  req_rx_ctl,
   input  logic [31:0] req_rx_index,
   input  logic [31:0] req_rx_ack,
   input  logic [7:0]  req_rx_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_local_ok,
   output logic [7:0]  rsp_rd_data,
   output logic        rsp_send_now,
   output logic [2:0]  rsp_dest_zone,
   output logic [1:0]  rsp_tx_ctl,
   output logic [31:0] rsp_tx_ack,
   output logic [31:0] rsp_tx_index,
   output logic [7:0]  rsp_tx_data
);

   logic               q_valid;
   logic               q_pop;
   swbc_pkg::item_type q_item;

   // Request intake and classification
   swbc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_wr_data  (req_wr_data),
      .req_rx_ctl   (req_rx_ctl),
      .req_rx_index (req_rx_index),
      .req_rx_ack   (req_rx_ack),
      .req_rx_data  (req_rx_data),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_item       (q_item)
   );

   // Execution and result register
   swbc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_partner_zone (csr_partner_zone),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_item           (q_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_local_ok     (rsp_local_ok),
      .rsp_rd_data      (rsp_rd_data),
      .rsp_send_now     (rsp_send_now),
      .rsp_dest_zone    (rsp_dest_zone),
      .rsp_tx_ctl       (rsp_tx_ctl),
      .rsp_tx_ack       (rsp_tx_ack),
      .rsp_tx_index     (rsp_tx_index),
      .rsp_tx_data      (rsp_tx_data)
   );

endmodule

### rtl/core/swbc_checker.sv
// ----------------------------------------------------------------------------
// swbc_checker
// Port-level checks on the result channel of the byte channel core.
// ----------------------------------------------------------------------------
module swbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_local_ok,
   input logic [7:0]  rsp_rd_data,
   input logic        rsp_send_now,
   input logic [2:0]  rsp_dest_zone,
   input logic [1:0]  rsp_tx_ctl,
   input logic [31:0] rsp_tx_ack,
   input logic [31:0] rsp_tx_index,
   input logic [7:0]  rsp_tx_data
);

   // No message: all mailbox fields are zero
   a_quiet_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_send_now |->
         rsp_dest_zone == 3'd0 && rsp_tx_ctl == 2'd0 && rsp_tx_ack == 32'd0
         && rsp_tx_index == 32'd0 && rsp_tx_data == 8'd0)
      else $error("mailbox fields set without a send");

   // A sent message always carries at least one flag
   a_send_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_now |-> rsp_tx_ctl != 2'd0)
      else $error("send with no flags");

   // Local and mailbox results never mix
   a_no_mix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_now |-> !rsp_local_ok && rsp_rd_data == 8'd0)
      else $error("local status on a mailbox result");

   // Stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tx_index)
         && $stable(rsp_rd_data) && $stable(rsp_send_now))
      else $error("stalled result changed");

endmodule

bind stop_and_wait_byte_channel_core swbc_checker u_checker (.*);

### sim/swbc_channel_checker.sv
// ----------------------------------------------------------------------------
// swbc_channel_checker
// Watches the control, request and result channels of the byte channel core.
// Keeps its own copy of the rings, the sequence state and the partner zone.
// Predicts one result word per accepted request word, in order, and compares
// every accepted result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module swbc_channel_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_partner_zone,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_wr_data,
   input  logic [1:0]  req_rx_ctl,
   input  logic [31:0] req_rx_index,
   input  logic [31:0] req_rx_ack,
   input  logic [7:0]  req_rx_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_local_ok,
   input  logic [7:0]  rsp_rd_data,
   input  logic        rsp_send_now,
   input  logic [2:0]  rsp_dest_zone,
   input  logic [1:0]  rsp_tx_ctl,
   input  logic [31:0] rsp_tx_ack,
   input  logic [31:0] rsp_tx_index,
   input  logic [7:0]  rsp_tx_data,
   output int unsigned fail_count,
   output int unsigned results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        local_ok;
      logic [7:0]  rd_data;
      logic        send_now;
      logic [2:0]  dest_zone;
      logic [1:0]  tx_ctl;
      logic [31:0] tx_ack;
      logic [31:0] tx_index;
      logic [7:0]  tx_data;
   } chan_result_type;

   // Shadow copy of the channel state
   logic [2:0]                 zone;
   logic [7:0]                 tx_bytes [swbc_pkg::RING_DEPTH];
   logic [7:0]                 rx_bytes [swbc_pkg::RING_DEPTH];
   logic [swbc_pkg::PTR_W-1:0] tx_rd, tx_wr, rx_rd, rx_wr;
   logic                       awaiting;
   logic [31:0]                next_seq;
   logic [31:0]                last_acc;
   logic [1:0]                 flags;
   logic [31:0]                out_index;
   logic [7:0]                 out_byte;

   chan_result_type  awaited_results [$];
   int unsigned      word_count;

   function automatic logic [swbc_pkg::PTR_W-1:0] ring_step(
      input logic [swbc_pkg::PTR_W-1:0] p);
      return (p == swbc_pkg::PTR_W'(swbc_pkg::RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Applies one request word to the shadow state, returns the result word
   task automatic apply_request(output chan_result_type r);
      logic send;
      r = '0;
      send = 1'b0;
      case (req_action)
         swbc_pkg::ACT_WRITE: begin
            // one slot always stays free
            if (tx_rd != ring_step(tx_wr)) begin
               tx_bytes[tx_wr] = req_wr_data;
               tx_wr = ring_step(tx_wr);
               r.local_ok = 1'b1;
            end
         end
         swbc_pkg::ACT_READ: begin
            if (rx_rd != rx_wr) begin
               r.rd_data = rx_bytes[rx_rd];
               rx_rd = ring_step(rx_rd);
               r.local_ok = 1'b1;
            end
         end
         swbc_pkg::ACT_STEP: begin
            // in-order data only, no full check on the receive ring
            if (req_rx_ctl[swbc_pkg::FLAG_DAT_BIT]
                && req_rx_index == last_acc + 32'd1) begin
               rx_bytes[rx_wr] = req_rx_data;
               rx_wr = ring_step(rx_wr);
               flags[swbc_pkg::FLAG_ACK_BIT] = 1'b1;
               last_acc = req_rx_index;
               send = 1'b1;
            end
            // a wrong ack still clears the outstanding byte, so it is resent
            if (req_rx_ctl[swbc_pkg::FLAG_ACK_BIT] && awaiting) begin
               if (req_rx_ack == next_seq) begin
                  tx_rd = ring_step(tx_rd);
                  next_seq = next_seq + 32'd1;
               end
               awaiting = 1'b0;
            end
            if (!awaiting && tx_rd != tx_wr) begin
               flags[swbc_pkg::FLAG_DAT_BIT] = 1'b1;
               out_index = next_seq;
               out_byte = tx_bytes[tx_rd];
               awaiting = 1'b1;
               send = 1'b1;
            end
            if (send) begin
               r.send_now  = 1'b1;
               r.dest_zone = zone;
               r.tx_ctl    = flags;
               r.tx_ack    = last_acc;
               r.tx_index  = out_index;
               r.tx_data   = out_byte;
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("result word %0d: %s expected %0h, got %0h",
                     word_count, field, want, got);
         end
      end
   endtask

   // Observe all three channels at each rising edge
   always @(posedge clock) begin
      chan_result_type want;
      if (reset) begin
         zone      = swbc_pkg::ZONE_RESET;
         tx_rd     = '0;
         tx_wr     = '0;
         rx_rd     = '0;
         rx_wr     = '0;
         awaiting  = 1'b0;
         next_seq  = '0;
         last_acc  = swbc_pkg::LAST_ACC_RESET;
         flags     = '0;
         out_index = '0;
         out_byte  = '0;
         awaited_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            zone = csr_partner_zone;
         end
         // result side first; a word cannot come back in its own cycle
         if (rsp_valid && !rsp_stall) begin
            word_count++;
            if (awaited_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("result word %0d arrived with nothing awaited", word_count);
               end
            end else begin
               want = awaited_results.pop_front();
               check_field("local_ok",  32'(want.local_ok),  32'(rsp_local_ok));
               check_field("rd_data",   32'(want.rd_data),   32'(rsp_rd_data));
               check_field("send_now",  32'(want.send_now),  32'(rsp_send_now));
               check_field("dest_zone", 32'(want.dest_zone), 32'(rsp_dest_zone));
               check_field("tx_ctl",    32'(want.tx_ctl),    32'(rsp_tx_ctl));
               check_field("tx_ack",    want.tx_ack,         rsp_tx_ack);
               check_field("tx_index",  want.tx_index,       rsp_tx_index);
               check_field("tx_data",   32'(want.tx_data),   32'(rsp_tx_data));
            end
         end
         if (req_valid && !req_stall) begin
            apply_request(want);
            awaited_results.push_back(want);
         end
      end
      results_due <= awaited_results.size();
   end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the stop-and-wait byte channel core. A short
// directed run covers empty reads, ignored acks, resends, in-order and
// duplicate data; random segments then fill the transmit ring, overflow the
// receive ring and drain both, with partner zone changes between segments.
// Sender bursts and receiver stalls are random; checking is in the checker.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [1:0] CTL_NONE   = 2'b00;
   localparam logic [1:0] CTL_ACK    = 2'(1 << swbc_pkg::FLAG_ACK_BIT);
   localparam logic [1:0] CTL_DAT    = 2'(1 << swbc_pkg::FLAG_DAT_BIT);
   localparam logic [1:0] CTL_BOTH   = CTL_ACK | CTL_DAT;

   localparam int RANDOM_ITEMS  = 400;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 8;
   localparam int LIMIT_NS      = 800_000;

   typedef enum {SEG_MIX, SEG_FILL_TX, SEG_FLOOD_RX, SEG_DRAIN} seg_kind_type;
   typedef enum {STALL_NONE, STALL_RANDOM, STALL_TOGGLE} stall_mode_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        csr_valid        = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_partner_zone = '0;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action       = '0;
   logic [7:0]  req_wr_data      = '0;
   logic [1:0]  req_rx_ctl       = '0;
   logic [31:0] req_rx_index     = '0;
   logic [31:0] req_rx_ack       = '0;
   logic [7:0]  req_rx_data      = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic        rsp_local_ok;
   logic [7:0]  rsp_rd_data;
   logic        rsp_send_now;
   logic [2:0]  rsp_dest_zone;
   logic [1:0]  rsp_tx_ctl;
   logic [31:0] rsp_tx_ack;
   logic [31:0] rsp_tx_index;
   logic [7:0]  rsp_tx_data;

   int unsigned fail_count;
   int unsigned results_due;

   // Partner view: next in-order index to send, last data index heard
   logic [31:0] rx_next     = '0;
   logic [31:0] heard_index = '0;
   int unsigned hold_requests = 0;
   int unsigned holds_done    = 0;
   int          burst_left    = 1;
   int unsigned plain_items   = 0;

   stop_and_wait_byte_channel_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_partner_zone (csr_partner_zone),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_wr_data      (req_wr_data),
      .req_rx_ctl       (req_rx_ctl),
      .req_rx_index     (req_rx_index),
      .req_rx_ack       (req_rx_ack),
      .req_rx_data      (req_rx_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_local_ok     (rsp_local_ok),
      .rsp_rd_data      (rsp_rd_data),
      .rsp_send_now     (rsp_send_now),
      .rsp_dest_zone    (rsp_dest_zone),
      .rsp_tx_ctl       (rsp_tx_ctl),
      .rsp_tx_ack       (rsp_tx_ack),
      .rsp_tx_index     (rsp_tx_index),
      .rsp_tx_data      (rsp_tx_data)
   );

   swbc_channel_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_partner_zone (csr_partner_zone),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_wr_data      (req_wr_data),
      .req_rx_ctl       (req_rx_ctl),
      .req_rx_index     (req_rx_index),
      .req_rx_ack       (req_rx_ack),
      .req_rx_data      (req_rx_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_local_ok     (rsp_local_ok),
      .rsp_rd_data      (rsp_rd_data),
      .rsp_send_now     (rsp_send_now),
      .rsp_dest_zone    (rsp_dest_zone),
      .rsp_tx_ctl       (rsp_tx_ctl),
      .rsp_tx_ack       (rsp_tx_ack),
      .rsp_tx_index     (rsp_tx_index),
      .rsp_tx_data      (rsp_tx_data),
      .fail_count       (fail_count),
      .results_due      (results_due)
   );

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Track the data index the block last sent, for acks
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall && rsp_send_now
          && rsp_tx_ctl[swbc_pkg::FLAG_DAT_BIT]) begin
         heard_index <= rsp_tx_index;
      end
   end

   // Offer one request word; bursts end in a random gap
   task automatic offer_word(input logic [1:0] action, input logic [7:0] wr_byte,
                             input logic [1:0] ctl, input logic [31:0] idx,
                             input logic [31:0] ack, input logic [7:0] rx_byte);
      int gap;
      req_valid    <= 1'b1;
      req_action   <= action;
      req_wr_data  <= wr_byte;
      req_rx_ctl   <= ctl;
      req_rx_index <= idx;
      req_rx_ack   <= ack;
      req_rx_data  <= rx_byte;
      if (action == swbc_pkg::ACT_STEP && ctl[swbc_pkg::FLAG_DAT_BIT] && idx == rx_next) begin
         rx_next = rx_next + 32'd1;
      end
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Mailbox step word, mostly in order and acking what was heard
   task automatic offer_step(input int dat_pct, input int ack_pct);
      logic [1:0]  ctl;
      logic [31:0] idx;
      logic [31:0] ack;
      ctl = CTL_NONE;
      if ($urandom_range(0, 99) < dat_pct) ctl = ctl | CTL_DAT;
      if ($urandom_range(0, 99) < ack_pct) ctl = ctl | CTL_ACK;
      case ($urandom_range(0, 19))
         0:       idx = rx_next - 32'd1;
         1:       idx = rx_next + 32'd1;
         2:       idx = $urandom;
         3:       idx = '1;
         default: idx = rx_next;
      endcase
      case ($urandom_range(0, 9))
         0:       ack = $urandom;
         1:       ack = heard_index + 32'd1;
         default: ack = heard_index;
      endcase
      offer_word(swbc_pkg::ACT_STEP, 8'($urandom), ctl, idx, ack, 8'($urandom));
   endtask

   task automatic run_segment(input seg_kind_type kind, input int count);
      int pick;
      int wr_pct, rd_pct, step_pct, dat_pct, ack_pct;
      case (kind)
         SEG_FILL_TX: begin
            wr_pct = 70; rd_pct = 5;  step_pct = 20; dat_pct = 60; ack_pct = 5;
         end
         SEG_FLOOD_RX: begin
            wr_pct = 5;  rd_pct = 0;  step_pct = 90; dat_pct = 95; ack_pct = 50;
         end
         SEG_DRAIN: begin
            wr_pct = 5;  rd_pct = 45; step_pct = 45; dat_pct = 30; ack_pct = 90;
         end
         default: begin
            wr_pct = 30; rd_pct = 20; step_pct = 42; dat_pct = 70; ack_pct = 70;
         end
      endcase
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < wr_pct) begin
            offer_word(swbc_pkg::ACT_WRITE, 8'($urandom), 2'($urandom), $urandom,
                       $urandom, 8'($urandom));
            plain_items++;
         end else if (pick < wr_pct + rd_pct) begin
            offer_word(swbc_pkg::ACT_READ, 8'($urandom), 2'($urandom), $urandom,
                       $urandom, 8'($urandom));
            plain_items++;
         end else if (pick < wr_pct + rd_pct + step_pct) begin
            offer_step(dat_pct, ack_pct);
            plain_items++;
         end else begin
            // noise: any action, any fields
            offer_word(2'($urandom), 8'($urandom), 2'($urandom), $urandom, $urandom,
                       8'($urandom));
         end
      end
   endtask

   // Stop offering and wait for every awaited result word
   task automatic settle_channel();
      if (req_valid) req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 1;
   endtask

   task automatic write_zone(input logic [2:0] zone);
      settle_channel();
      csr_partner_zone <= zone;
      csr_valid        <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Result side stall pattern, with long hold-offs on request
   initial begin
      stall_mode_type mode;
      int             span;
      while (reset) @(posedge clock);
      forever begin
         mode = stall_mode_type'($urandom_range(0, 2));
         span = $urandom_range(10, 60);
         repeat (span) begin
            @(posedge clock);
            if (holds_done < hold_requests) begin
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
               rsp_stall <= 1'b0;
               holds_done++;
            end else begin
               case (mode)
                  STALL_NONE:   rsp_stall <= 1'b0;
                  STALL_RANDOM: rsp_stall <= ($urandom_range(0, 99) < 40);
                  default:      rsp_stall <= ~rsp_stall;
               endcase
            end
         end
      end
   end

   // Main stimulus
   initial begin
      seg_kind_type kind;
      int           seg;
      logic [2:0]   zone;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: partner zone still at its reset value
      offer_word(swbc_pkg::ACT_READ,  8'h00, CTL_NONE, '0, '0, 8'h00);     // empty read
      offer_word(swbc_pkg::ACT_STEP,  8'h00, CTL_NONE, '0, '0, 8'h00);     // nothing to do
      offer_word(ACT_UNUSED,          8'hFF, CTL_BOTH, '1, '1, 8'hFF);     // unused action
      offer_word(swbc_pkg::ACT_STEP,  8'h00, CTL_ACK,  '0, '0, 8'h00);     // ack while idle
      offer_word(swbc_pkg::ACT_WRITE, 8'h00, CTL_NONE, '0, '0, 8'h00);
      offer_word(swbc_pkg::ACT_WRITE, 8'hFF, CTL_NONE, '0, '0, 8'h00);
      offer_word(swbc_pkg::ACT_STEP,  8'h00, CTL_NONE, '0, '0, 8'h00);     // first send
      offer_word(swbc_pkg::ACT_STEP,  8'h00, CTL_ACK,  '0, '1, 8'h00);     // wrong ack, resend
      offer_word(swbc_pkg::ACT_STEP,  8'h00, CTL_DAT,  32'd1, '0, 8'h5A);  // out of order
      offer_word(swbc_pkg::ACT_STEP,  8'h00, CTL_BOTH, 32'd0, 32'd0, 8'hFF); // index wraps
      offer_word(swbc_pkg::ACT_STEP,  8'h00, CTL_BOTH, 32'd1, 32'd1, 8'h00); // ring drains
      offer_word(swbc_pkg::ACT_READ,  8'h00, CTL_NONE, '0, '0, 8'h00);
      offer_word(swbc_pkg::ACT_READ,  8'h00, CTL_NONE, '0, '0, 8'h00);
      offer_word(swbc_pkg::ACT_READ,  8'h00, CTL_NONE, '0, '0, 8'h00);     // empty again
      offer_word(swbc_pkg::ACT_STEP,  8'h00, CTL_ACK,  '0, 32'd2, 8'h00);  // idle ack ignored
      offer_word(swbc_pkg::ACT_STEP,  8'h00, CTL_DAT,  32'd2, '0, 8'hA5);
      offer_word(swbc_pkg::ACT_STEP,  8'h00, CTL_DAT,  32'd2, '0, 8'h3C);  // duplicate
      offer_word(swbc_pkg::ACT_READ,  8'h00, CTL_NONE, '0, '0, 8'h00);
      offer_word(swbc_pkg::ACT_WRITE, 8'h80, CTL_NONE, '0, '0, 8'h00);
      offer_word(swbc_pkg::ACT_STEP,  8'h00, CTL_ACK,  '0, '0, 8'h00);     // idle ack, send
      offer_word(swbc_pkg::ACT_STEP,  8'h00, CTL_ACK,  '0, 32'd2, 8'h00);  // correct ack
      offer_word(swbc_pkg::ACT_STEP,  8'h00, CTL_BOTH, 32'd3, 32'd3, 8'h01); // sticky flags

      // random segments, zone changes while quiet
      seg = 0;
      while (plain_items < RANDOM_ITEMS) begin
         if (seg % 3 == 2) begin
            case ((seg / 3) % 3)
               0:       zone = 3'd0;
               1:       zone = 3'd7;
               default: zone = 3'($urandom_range(1, 6));
            endcase
            write_zone(zone);
         end
         case (seg)
            0:       kind = SEG_FILL_TX;
            1:       kind = SEG_FLOOD_RX;
            2:       kind = SEG_DRAIN;
            3:       kind = SEG_MIX;
            default: kind = seg_kind_type'($urandom_range(0, 3));
         endcase
         if (seg == 3 || seg == 9) begin
            // back up the block against a long result hold-off
            hold_requests++;
            burst_left = 120;
         end
         run_segment(kind, (seg < 2) ? 70 : $urandom_range(25, 50));
         seg++;
      end

      settle_channel();
      if (fail_count == 0 && results_due == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Run limit
   initial begin
      #(LIMIT_NS);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
